// ----- hdl/lpc_pkg.sv -----
// ----------------------------------------------------------------------------
// lpc_pkg
// shared constants and types of the lru page cache with fetch buffers
// ----------------------------------------------------------------------------
package lpc_pkg;

  localparam int PAGE_BITS = 9;
  localparam int NUM_SLOTS = 16;
  localparam int ADDR_BITS = 19;
  localparam int SLOT_BITS = $clog2(NUM_SLOTS);
  localparam int TAG_BITS  = ADDR_BITS - PAGE_BITS;
  localparam int RES_BITS  = 20;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 32;

  localparam logic CMD_CODE = 1'b0;
  localparam logic CMD_DATA = 1'b1;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_DECIDE = 5'b00010,
    ST_SCAN   = 5'b00100,
    ST_UPDATE = 5'b01000,
    ST_DONE   = 5'b10000
  } state_e;

  typedef struct packed {
    logic [TAG_BITS-1:0]  fill_page;
    logic                 fill_needed;
    logic [PAGE_BITS-1:0] byte_offset;
    logic [SLOT_BITS-1:0] slot;
    logic                 cache_hit;
    logic                 buffer_hit;
    logic                 from_resident;
  } result_t;

endpackage

// ----- hdl/lru_page_cache_with_fetch_buffers_unit.sv -----
// ----------------------------------------------------------------------------
// lru_page_cache_with_fetch_buffers_unit
// page lookup with code and data fetch buffers and a fully associative lru
// page cache, searched one slot per cycle by a shared compare unit
// ----------------------------------------------------------------------------
// usage:
//   the slave channel takes one read request per transaction: tuser holds the
//   kind (code fetch or data read), tdata the byte address. the master
//   channel returns one result per request: resident flag, buffer and cache
//   hit flags, slot, byte offset and the fill request.
//   resident_bytes is written through cfg_we_i / cfg_wdata_i; the user must
//   do so only while idle, as the block does not enforce this.
//   a resident read or a buffer hit passes through decide and done into the
//   output register; a cache lookup passes through decide, the slot search
//   that compares one slot tag and age per cycle, update and done likewise.
//   one request is worked on at a time; a new request is taken only once the
//   result sits in the output register.
//   reset empties all slots and both buffers, sets the recency order to slot
//   index order and clears resident_bytes.
//   when the receiver stalls, the result is held and the block completes at
//   most one more request, which then waits for the output register.
// ----------------------------------------------------------------------------
module lru_page_cache_with_fetch_buffers_unit
  import lpc_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [RES_BITS-1:0]   cfg_wdata_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [18:0] address, [23:19] zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [0] cmd
  input  logic [0:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [0] from_resident, [1] buffer_hit, [2] cache_hit, [6:3] slot,
  // [15:7] byte_offset, [16] fill_needed, [26:17] fill_page, [31:27] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  state_e state_q, state_d;

  logic [RES_BITS-1:0]  resident_q;

  logic                 cmd_q;
  logic [ADDR_BITS-1:0] addr_q;
  logic [TAG_BITS-1:0]  page;
  logic [PAGE_BITS-1:0] offset;

  logic [TAG_BITS-1:0]  tag_q [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] valid_q, valid_d;
  logic [SLOT_BITS-1:0] age_q [NUM_SLOTS];
  logic [SLOT_BITS-1:0] age_d [NUM_SLOTS];

  logic                 cbuf_valid_q, cbuf_valid_d;
  logic [TAG_BITS-1:0]  cbuf_page_q;
  logic [SLOT_BITS-1:0] cbuf_slot_q;
  logic                 dbuf_valid_q, dbuf_valid_d;
  logic [TAG_BITS-1:0]  dbuf_page_q;
  logic [SLOT_BITS-1:0] dbuf_slot_q;

  logic [SLOT_BITS-1:0] cnt_q;
  logic                 found_q, have_free_q;
  logic [SLOT_BITS-1:0] match_slot_q, free_slot_q, free_age_q, lru_slot_q, lru_age_q;

  result_t              res_q, res_d;
  logic                 out_valid_q;
  result_t              out_q;

  logic                 is_resident, cbuf_hit, dbuf_hit;
  logic                 scan_match, scan_free, scan_lru;
  logic [SLOT_BITS-1:0] sel_slot, sel_age;
  logic                 evict;
  logic                 out_free;

  assign page   = addr_q[ADDR_BITS-1:PAGE_BITS];
  assign offset = addr_q[PAGE_BITS-1:0];

  assign is_resident = (cmd_q == CMD_DATA) && ({1'b0, addr_q} < resident_q);
  assign cbuf_hit    = (cmd_q == CMD_CODE) && cbuf_valid_q && (cbuf_page_q == page);
  assign dbuf_hit    = (cmd_q == CMD_DATA) && dbuf_valid_q && (dbuf_page_q == page);

  // shared compare unit, one slot per cycle
  assign scan_match = valid_q[cnt_q] && (tag_q[cnt_q] == page);
  assign scan_free  = !valid_q[cnt_q] && (!have_free_q || (age_q[cnt_q] < free_age_q));
  assign scan_lru   = (cnt_q == '0) || (age_q[cnt_q] > lru_age_q);

  assign sel_slot = found_q ? match_slot_q : (have_free_q ? free_slot_q : lru_slot_q);
  assign sel_age  = age_q[sel_slot];
  assign evict    = !found_q && !have_free_q;

  assign out_free = !out_valid_q || m_axis_tready;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - $bits(result_t)){1'b0}}, out_q};

  always_comb begin
    state_d      = state_q;
    res_d        = res_q;
    valid_d      = valid_q;
    age_d        = age_q;
    cbuf_valid_d = cbuf_valid_q;
    dbuf_valid_d = dbuf_valid_q;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        res_d             = '0;
        res_d.byte_offset = offset;
        if (is_resident) begin
          res_d.from_resident = 1'b1;
          state_d             = ST_DONE;
        end else if (cbuf_hit) begin
          res_d.buffer_hit = 1'b1;
          res_d.slot       = cbuf_slot_q;
          state_d          = ST_DONE;
        end else if (dbuf_hit) begin
          res_d.buffer_hit = 1'b1;
          res_d.slot       = dbuf_slot_q;
          state_d          = ST_DONE;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt_q == SLOT_BITS'(NUM_SLOTS - 1)) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        res_d.slot        = sel_slot;
        res_d.cache_hit   = found_q;
        res_d.fill_needed = !found_q;
        res_d.fill_page   = found_q ? '0 : page;
        if (!found_q) begin
          valid_d[sel_slot] = 1'b1;
        end
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (age_q[i] < sel_age) begin
            age_d[i] = age_q[i] + 1'b1;
          end
        end
        age_d[sel_slot] = '0;
        if (evict && cbuf_valid_q && (cbuf_slot_q == sel_slot)) begin
          cbuf_valid_d = 1'b0;
        end
        if (evict && dbuf_valid_q && (dbuf_slot_q == sel_slot)) begin
          dbuf_valid_d = 1'b0;
        end
        if (cmd_q == CMD_CODE) begin
          cbuf_valid_d = 1'b1;
        end else begin
          dbuf_valid_d = 1'b1;
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      resident_q   <= '0;
      valid_q      <= '0;
      cbuf_valid_q <= 1'b0;
      dbuf_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      cnt_q        <= '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        age_q[i] <= SLOT_BITS'(i);
      end
    end else begin
      state_q      <= state_d;
      valid_q      <= valid_d;
      age_q        <= age_d;
      cbuf_valid_q <= cbuf_valid_d;
      dbuf_valid_q <= dbuf_valid_d;
      if (cfg_we_i) begin
        resident_q <= cfg_wdata_i;
      end
      if (state_q == ST_DECIDE) begin
        cnt_q <= '0;
      end else if (state_q == ST_SCAN) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if ((state_q == ST_DONE) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    if ((state_q == ST_IDLE) && s_axis_tvalid) begin
      cmd_q  <= s_axis_tuser[0];
      addr_q <= s_axis_tdata[ADDR_BITS-1:0];
    end
    if (state_q == ST_DECIDE) begin
      found_q     <= 1'b0;
      have_free_q <= 1'b0;
    end
    if (state_q == ST_SCAN) begin
      if (scan_match) begin
        found_q      <= 1'b1;
        match_slot_q <= cnt_q;
      end
      if (scan_free) begin
        have_free_q <= 1'b1;
        free_slot_q <= cnt_q;
        free_age_q  <= age_q[cnt_q];
      end
      if (scan_lru) begin
        lru_slot_q <= cnt_q;
        lru_age_q  <= age_q[cnt_q];
      end
    end
    if ((state_q == ST_UPDATE) && !found_q) begin
      tag_q[sel_slot] <= page;
    end
    if ((state_q == ST_UPDATE) && (cmd_q == CMD_CODE)) begin
      cbuf_page_q <= page;
      cbuf_slot_q <= sel_slot;
    end
    if ((state_q == ST_UPDATE) && (cmd_q == CMD_DATA)) begin
      dbuf_page_q <= page;
      dbuf_slot_q <= sel_slot;
    end
    if ((state_q == ST_DONE) && out_free) begin
      out_q <= res_q;
    end
  end

endmodule
